// ----- src/dtepoch_pkg.sv -----
// Shared types, error codes and constants of the timestamp-to-epoch converter.
`default_nettype none
package dtepoch_pkg;

  localparam int unsigned FIELD_COUNT  = 6;
  localparam int unsigned CHARS_NEEDED = 23;

  // Result error codes, lowest value has highest priority after ok
  localparam logic [3:0] ERR_OK     = 4'd0;
  localparam logic [3:0] ERR_SHORT  = 4'd1;
  localparam logic [3:0] ERR_SEP    = 4'd2;
  localparam logic [3:0] ERR_NUMBER = 4'd3;
  localparam logic [3:0] ERR_MONTH  = 4'd4;
  localparam logic [3:0] ERR_DAY    = 4'd5;
  localparam logic [3:0] ERR_HOUR   = 4'd6;
  localparam logic [3:0] ERR_MINUTE = 4'd7;
  localparam logic [3:0] ERR_SECOND = 4'd8;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } char_item_t;

  typedef struct packed {
    logic signed [39:0] epoch_seconds;
    logic [3:0]         error_code;
  } result_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;       // character transaction accepted
    logic calc_date;  // range checks, shifted year, day of year, time of day
    logic calc_era;   // quotient of shifted year by 400
    logic calc_yoe;   // year of era and era day count
    logic calc_days;  // days since epoch
    logic load_out;   // seconds into output register, clear fields
  } dp_cmd_t;

  // Days before the first of a month, months counted from March
  function automatic logic [8:0] month_day_base(input logic [3:0] mp);
    logic [8:0] base;
    case (mp)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd61;
      4'd3:    base = 9'd92;
      4'd4:    base = 9'd122;
      4'd5:    base = 9'd153;
      4'd6:    base = 9'd184;
      4'd7:    base = 9'd214;
      4'd8:    base = 9'd245;
      4'd9:    base = 9'd275;
      4'd10:   base = 9'd306;
      4'd11:   base = 9'd337;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage
`default_nettype wire

// ----- src/dtepoch_ctrl.sv -----
// Sequencer for character collection, calendar conversion steps and result hand-off.
`default_nettype none
module dtepoch_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                char_valid,
  input  wire logic                is_last,
  output logic                     char_stall,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output dtepoch_pkg::dp_cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_DATE,
    ST_ERA,
    ST_YOE,
    ST_DAYS,
    ST_PUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign char_stall = (state != ST_COLLECT);
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        cmd.take = char_valid;
        if (char_valid && is_last) state_next = ST_DATE;
      end
      ST_DATE: begin
        cmd.calc_date = 1'b1;
        state_next    = ST_ERA;
      end
      ST_ERA: begin
        cmd.calc_era = 1'b1;
        state_next   = ST_YOE;
      end
      ST_YOE: begin
        cmd.calc_yoe = 1'b1;
        state_next   = ST_DAYS;
      end
      ST_DAYS: begin
        cmd.calc_days = 1'b1;
        state_next    = ST_PUT;
      end
      ST_PUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_COLLECT;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- src/dtepoch_dp.sv -----
// Field parsing registers and days-from-civil arithmetic steps.
`default_nettype none
module dtepoch_dp (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire dtepoch_pkg::dp_cmd_t   cmd,
  input  wire dtepoch_pkg::char_item_t char_item,
  output dtepoch_pkg::result_item_t   result_item
);

  localparam int unsigned NF = dtepoch_pkg::FIELD_COUNT;

  // parse state
  logic [4:0]  pos;
  logic [13:0] fval [NF];
  logic [NF-1:0] fneg;
  logic [NF-1:0] fdig;
  logic        sep_fault;
  logic        num_fault;

  // arithmetic step registers
  logic [3:0]         err_r;
  logic [13:0]        x_r;       // year after March shift, plus 1200
  logic [8:0]         doy_r;
  logic [16:0]        hms_r;
  logic [4:0]         q_r;
  logic [8:0]         yoe_r;
  logic signed [22:0] era_term_r;
  logic signed [22:0] days_r;

  // character decode
  logic       is_field;
  logic [2:0] fsel;
  logic       first;
  logic       sep_chk;
  logic       sep_ok;
  logic       is_digit;
  logic [7:0] c;
  logic [17:0] acc;

  assign c        = char_item.char_code;
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign acc      = 18'(fval[fsel]) * 18'd10 + 18'(c - 8'h30);

  always_comb begin
    is_field = 1'b0;
    fsel     = 3'd0;
    first    = 1'b0;
    sep_chk  = 1'b0;
    sep_ok   = 1'b1;
    case (pos)
      5'd0, 5'd1, 5'd2, 5'd3: begin
        is_field = 1'b1; fsel = 3'd0; first = (pos == 5'd0);
      end
      5'd5, 5'd6: begin
        is_field = 1'b1; fsel = 3'd1; first = (pos == 5'd5);
      end
      5'd8, 5'd9: begin
        is_field = 1'b1; fsel = 3'd2; first = (pos == 5'd8);
      end
      5'd11, 5'd12: begin
        is_field = 1'b1; fsel = 3'd3; first = (pos == 5'd11);
      end
      5'd14, 5'd15: begin
        is_field = 1'b1; fsel = 3'd4; first = (pos == 5'd14);
      end
      5'd17, 5'd18: begin
        is_field = 1'b1; fsel = 3'd5; first = (pos == 5'd17);
      end
      5'd4, 5'd7: begin
        sep_chk = 1'b1; sep_ok = (c == 8'h2D);
      end
      5'd10: begin
        sep_chk = 1'b1; sep_ok = (c == 8'h20);
      end
      5'd13, 5'd16, 5'd22: begin
        sep_chk = 1'b1; sep_ok = (c == 8'h3A);
      end
      5'd19: begin
        sep_chk = 1'b1; sep_ok = (c == 8'h2B) || (c == 8'h2D);
      end
      default: ;  // offset digits and beyond
    endcase
  end

  // range checks and first-step values
  logic        short_in;
  logic        num_bad;
  logic        month_ok, day_ok, hour_ok, minute_ok, second_ok;
  logic [3:0]  err_next;
  logic signed [15:0] y_val;
  logic signed [15:0] y_adj;
  logic [15:0] x_full;
  logic [3:0]  mp;
  logic [8:0]  doy_next;
  logic [16:0] hms_next;

  assign short_in  = (pos < 5'(dtepoch_pkg::CHARS_NEEDED));
  assign num_bad   = num_fault || !(&fdig);
  assign month_ok  = !fneg[1] && (fval[1] >= 14'd1) && (fval[1] <= 14'd12);
  assign day_ok    = !fneg[2] && (fval[2] >= 14'd1) && (fval[2] <= 14'd31);
  assign hour_ok   = fneg[3] ? (fval[3] == 14'd0) : (fval[3] <= 14'd23);
  assign minute_ok = fneg[4] ? (fval[4] == 14'd0) : (fval[4] <= 14'd59);
  assign second_ok = fneg[5] ? (fval[5] == 14'd0) : (fval[5] <= 14'd60);

  always_comb begin
    if (short_in)        err_next = dtepoch_pkg::ERR_SHORT;
    else if (sep_fault)  err_next = dtepoch_pkg::ERR_SEP;
    else if (num_bad)    err_next = dtepoch_pkg::ERR_NUMBER;
    else if (!month_ok)  err_next = dtepoch_pkg::ERR_MONTH;
    else if (!day_ok)    err_next = dtepoch_pkg::ERR_DAY;
    else if (!hour_ok)   err_next = dtepoch_pkg::ERR_HOUR;
    else if (!minute_ok) err_next = dtepoch_pkg::ERR_MINUTE;
    else if (!second_ok) err_next = dtepoch_pkg::ERR_SECOND;
    else                 err_next = dtepoch_pkg::ERR_OK;
  end

  assign y_val    = fneg[0] ? -$signed({2'b00, fval[0]}) : $signed({2'b00, fval[0]});
  assign y_adj    = (fval[1] <= 14'd2) ? (y_val - 16'sd1) : y_val;
  assign x_full   = 16'(y_adj + 16'sd1200);  // non-negative for any four-char year
  assign mp       = (fval[1] > 14'd2) ? (fval[1][3:0] - 4'd3) : (fval[1][3:0] + 4'd9);
  assign doy_next = dtepoch_pkg::month_day_base(mp) + 9'(fval[2][4:0]) - 9'd1;
  assign hms_next = 17'(fval[3][4:0]) * 17'd3600 + 17'(fval[4][5:0]) * 17'd60
                  + 17'(fval[5][5:0]);

  // x / 400 = (x / 16) / 25, and n / 25 = (n * 41) >> 10 for n below 1000
  logic [15:0] q_prod;
  assign q_prod = 16'(x_r[13:4]) * 16'd41;

  logic [13:0]        q400;
  logic signed [5:0]  era;
  logic signed [22:0] era_term_next;
  assign q400          = 14'(q_r) * 14'd400;
  assign era           = $signed({1'b0, q_r}) - 6'sd3;
  assign era_term_next = 23'(era) * 23'sd146097;

  logic [6:0]         yq;
  logic [13:0]        c_prod;
  logic [17:0]        t_sum;
  logic signed [22:0] days_next;
  assign yq        = yoe_r[8:2];
  assign c_prod    = 14'(yq) * 14'd41;
  assign t_sum     = 18'(yoe_r) * 18'd365 + 18'(yq) + 18'(doy_r);
  assign days_next = era_term_r + $signed({5'b0, t_sum})
                   - $signed({20'b0, c_prod[12:10]}) - 23'sd719468;

  logic signed [39:0] secs;
  assign secs = 40'(days_r) * 40'sd86400 + $signed({23'b0, hms_r});

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      pos       <= '0;
      fneg      <= '0;
      fdig      <= '0;
      sep_fault <= 1'b0;
      num_fault <= 1'b0;
      for (int i = 0; i < NF; i++) fval[i] <= '0;
    end else if (cmd.take && short_in) begin
      pos <= pos + 5'd1;
      if (is_field) begin
        if (first && (c == 8'h2D)) begin
          fneg[fsel] <= 1'b1;
        end else if (is_digit) begin
          fval[fsel] <= acc[13:0];
          fdig[fsel] <= 1'b1;
        end else begin
          num_fault <= 1'b1;
        end
      end else if (sep_chk && !sep_ok) begin
        sep_fault <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_date) begin
      err_r <= err_next;
      x_r   <= x_full[13:0];
      doy_r <= doy_next;
      hms_r <= hms_next;
    end
    if (cmd.calc_era) q_r <= q_prod[14:10];
    if (cmd.calc_yoe) begin
      yoe_r      <= 9'(x_r - q400);
      era_term_r <= era_term_next;
    end
    if (cmd.calc_days) days_r <= days_next;
    if (cmd.load_out) begin
      result_item.error_code    <= err_r;
      result_item.epoch_seconds <= (err_r == dtepoch_pkg::ERR_OK) ? secs : '0;
    end
  end

endmodule
`default_nettype wire

// ----- src/datetime_text_to_epoch_seconds_unit.sv -----
// Top level: 'YYYY-MM-DD HH:MM:SS+hh:mm' text stream to signed epoch seconds.
// Usage:
//  - Input channel (char_valid / char_stall / char_item): one character per
//    transaction; is_last marks the final character of a timestamp.
//  - Output channel (result_valid / result_stall / result_item): exactly one
//    transaction per timestamp with epoch_seconds (0 on error) and error_code.
//  - Characters are taken one per cycle. After the last character the block
//    stalls the input while the calendar math runs as four
//    register-to-register steps (range checks, divide by 400, year of era,
//    day count) followed by the seconds multiply into the output register.
//  - One timestamp is converted at a time: the next timestamp's characters
//    are taken only once the conversion sequence has loaded the result.
//  - The output register decouples the two sides: the next timestamp's
//    characters are taken while a result waits. If the receiver still
//    stalls when the next result is ready, the block holds it and keeps
//    char_stall high until the output register frees up.
//  - Characters after position 22 are ignored; offset digits are not used.
//  - Reset (rst, synchronous) clears the parse state and drops result_valid.
`default_nettype none
module datetime_text_to_epoch_seconds_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       char_valid,
  output logic                            char_stall,
  input  wire dtepoch_pkg::char_item_t    char_item,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output dtepoch_pkg::result_item_t       result_item
);

  dtepoch_pkg::dp_cmd_t cmd;

  // sequencer: owns handshake state and steps the datapath
  dtepoch_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .is_last      (char_item.is_last),
    .char_stall   (char_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  // datapath: field parse registers, conversion steps, output register
  dtepoch_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .char_item   (char_item),
    .result_item (result_item)
  );

endmodule
`default_nettype wire
